>>> hw/rtl/rbci_pkg.sv
// Shared types, constants and the microcode table of the rigid body contact impulse block.
// Arithmetic helpers for Q16.16 saturation. No dependencies.
package rbci_pkg;

  // Table size and derived address width
  localparam int BODY_COUNT = 64;
  localparam int ADDR_W     = $clog2(BODY_COUNT);
  localparam int IDX_W      = 6;
  localparam int REST_W     = 17;
  localparam int NUM_TMP    = 8;
  localparam int PC_W       = 7;
  localparam int DIV_STEPS  = 48;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic signed [31:0] Q_ONE    = 32'sd65536;
  localparam logic signed [31:0] Q_HALF   = 32'sd32768;
  localparam logic signed [31:0] Q_MAX    = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN    = 32'sh80000000;
  localparam logic [REST_W-1:0]  REST_RESET = 17'd26214;

  // Action codes
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CONTACT = 2'd2;
  localparam logic [1:0] ACT_CORRECT = 2'd3;

  // Program entry points
  localparam logic [PC_W-1:0] PC_WRITE   = 7'd0;
  localparam logic [PC_W-1:0] PC_CONTACT = 7'd9;
  localparam logic [PC_W-1:0] PC_CORRECT = 7'd71;

  // Body record as stored in the table
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic signed [31:0] mass;
    logic signed [31:0] inv_mass;
    logic signed [31:0] inv_inertia;
    logic               fixed;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  // Field indexes inside a body record
  localparam logic [2:0] FLD_PX = 3'd0;
  localparam logic [2:0] FLD_PY = 3'd1;
  localparam logic [2:0] FLD_VX = 3'd2;
  localparam logic [2:0] FLD_VY = 3'd3;
  localparam logic [2:0] FLD_SP = 3'd4;
  localparam logic [2:0] FLD_MS = 3'd5;
  localparam logic [2:0] FLD_IM = 3'd6;
  localparam logic [2:0] FLD_II = 3'd7;

  // Operand groups: upper three bits of an operand code
  localparam logic [2:0] GRP_A = 3'd2;
  localparam logic [2:0] GRP_B = 3'd3;
  localparam logic [2:0] GRP_T = 3'd4;

  // Operand codes: constants and item fields
  localparam logic [5:0] O_ZERO  = 6'd0;
  localparam logic [5:0] O_ONE   = 6'd1;
  localparam logic [5:0] O_HALF  = 6'd2;
  localparam logic [5:0] O_PX    = 6'd3;
  localparam logic [5:0] O_PY    = 6'd4;
  localparam logic [5:0] O_NX    = 6'd5;
  localparam logic [5:0] O_NY    = 6'd6;
  localparam logic [5:0] O_REST1 = 6'd7;
  localparam logic [5:0] O_SPIN  = 6'd8;
  localparam logic [5:0] O_MASS  = 6'd9;
  localparam logic [5:0] O_INER  = 6'd10;
  // Body A fields
  localparam logic [5:0] OA_PX = {GRP_A, FLD_PX};
  localparam logic [5:0] OA_PY = {GRP_A, FLD_PY};
  localparam logic [5:0] OA_VX = {GRP_A, FLD_VX};
  localparam logic [5:0] OA_VY = {GRP_A, FLD_VY};
  localparam logic [5:0] OA_SP = {GRP_A, FLD_SP};
  localparam logic [5:0] OA_MS = {GRP_A, FLD_MS};
  localparam logic [5:0] OA_IM = {GRP_A, FLD_IM};
  localparam logic [5:0] OA_II = {GRP_A, FLD_II};
  // Body B fields
  localparam logic [5:0] OB_PX = {GRP_B, FLD_PX};
  localparam logic [5:0] OB_PY = {GRP_B, FLD_PY};
  localparam logic [5:0] OB_VX = {GRP_B, FLD_VX};
  localparam logic [5:0] OB_VY = {GRP_B, FLD_VY};
  localparam logic [5:0] OB_SP = {GRP_B, FLD_SP};
  localparam logic [5:0] OB_MS = {GRP_B, FLD_MS};
  localparam logic [5:0] OB_IM = {GRP_B, FLD_IM};
  localparam logic [5:0] OB_II = {GRP_B, FLD_II};
  // Scratch registers
  localparam logic [5:0] OT0 = {GRP_T, 3'd0};
  localparam logic [5:0] OT1 = {GRP_T, 3'd1};
  localparam logic [5:0] OT2 = {GRP_T, 3'd2};
  localparam logic [5:0] OT3 = {GRP_T, 3'd3};
  localparam logic [5:0] OT4 = {GRP_T, 3'd4};
  localparam logic [5:0] OT5 = {GRP_T, 3'd5};
  localparam logic [5:0] OT6 = {GRP_T, 3'd6};
  localparam logic [5:0] OT7 = {GRP_T, 3'd7};

  typedef enum logic [2:0] {
    U_ADD, U_SUB, U_NEG, U_MUL, U_DIV, U_DIVZ, U_TEST, U_END
  } op_t;

  typedef enum logic [2:0] {
    C_ALL, C_AMOV, C_BMOV, C_BOTH, C_AFIX, C_BFIX, C_FLAG, C_NFLAG
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [5:0] dst;
    logic [5:0] sx;
    logic [5:0] sy;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_LDB, ST_RUN, ST_DIVW, ST_WBA, ST_WBB, ST_DONE
  } state_t;

  // Divider request from the sequencer
  typedef struct packed {
    logic start;
    logic zero_to_zero;
  } div_req_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007fffffff) r = Q_MAX;
    else if (v < -64'sh0000000080000000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input op_t o, input cond_t c, input logic [5:0] d,
                              input logic [5:0] x, input logic [5:0] y);
    uop_t u;
    u.op = o; u.cond = c; u.dst = d; u.sx = x; u.sy = y;
    return u;
  endfunction

  // Microcode: write body, contact impulse, penetration correction
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // write body
      7'd0:  u = mk(U_ADD, C_ALL, OA_PX, O_PX, O_ZERO);
      7'd1:  u = mk(U_ADD, C_ALL, OA_PY, O_PY, O_ZERO);
      7'd2:  u = mk(U_ADD, C_ALL, OA_VX, O_NX, O_ZERO);
      7'd3:  u = mk(U_ADD, C_ALL, OA_VY, O_NY, O_ZERO);
      7'd4:  u = mk(U_ADD, C_ALL, OA_SP, O_SPIN, O_ZERO);
      7'd5:  u = mk(U_ADD, C_ALL, OA_MS, O_MASS, O_ZERO);
      7'd6:  u = mk(U_DIV, C_ALL, OA_IM, O_ONE, O_MASS);
      7'd7:  u = mk(U_DIV, C_ALL, OA_II, O_ONE, O_INER);
      7'd8:  u = mk(U_END, C_ALL, O_ZERO, O_ZERO, O_ZERO);
      // contact: point velocities and normal speed
      7'd9:  u = mk(U_SUB, C_ALL, OT0, O_PX, OA_PX);
      7'd10: u = mk(U_SUB, C_ALL, OT1, O_PY, OA_PY);
      7'd11: u = mk(U_MUL, C_ALL, OT2, OT1, OA_SP);
      7'd12: u = mk(U_NEG, C_ALL, OT2, OT2, O_ZERO);
      7'd13: u = mk(U_ADD, C_ALL, OT2, OA_VX, OT2);
      7'd14: u = mk(U_MUL, C_ALL, OT3, OT0, OA_SP);
      7'd15: u = mk(U_ADD, C_ALL, OT3, OA_VY, OT3);
      7'd16: u = mk(U_SUB, C_ALL, OT4, O_PX, OB_PX);
      7'd17: u = mk(U_SUB, C_ALL, OT5, O_PY, OB_PY);
      7'd18: u = mk(U_MUL, C_ALL, OT6, OT5, OB_SP);
      7'd19: u = mk(U_NEG, C_ALL, OT6, OT6, O_ZERO);
      7'd20: u = mk(U_ADD, C_ALL, OT6, OB_VX, OT6);
      7'd21: u = mk(U_SUB, C_ALL, OT2, OT2, OT6);
      7'd22: u = mk(U_MUL, C_ALL, OT6, OT4, OB_SP);
      7'd23: u = mk(U_ADD, C_ALL, OT6, OB_VY, OT6);
      7'd24: u = mk(U_SUB, C_ALL, OT3, OT3, OT6);
      7'd25: u = mk(U_MUL, C_ALL, OT2, OT2, O_NX);
      7'd26: u = mk(U_MUL, C_ALL, OT3, OT3, O_NY);
      7'd27: u = mk(U_ADD, C_ALL, OT2, OT2, OT3);
      7'd28: u = mk(U_TEST, C_ALL, O_ZERO, OT2, O_ZERO);
      // effective mass denominator
      7'd29: u = mk(U_ADD, C_ALL, OT3, O_ZERO, O_ZERO);
      7'd30: u = mk(U_MUL, C_AMOV, OT6, OT0, O_NY);
      7'd31: u = mk(U_MUL, C_AMOV, OT7, OT1, O_NX);
      7'd32: u = mk(U_SUB, C_AMOV, OT6, OT6, OT7);
      7'd33: u = mk(U_MUL, C_AMOV, OT6, OT6, OT6);
      7'd34: u = mk(U_MUL, C_AMOV, OT6, OT6, OA_II);
      7'd35: u = mk(U_ADD, C_AMOV, OT6, OA_IM, OT6);
      7'd36: u = mk(U_ADD, C_AMOV, OT3, OT3, OT6);
      7'd37: u = mk(U_MUL, C_BMOV, OT6, OT4, O_NY);
      7'd38: u = mk(U_MUL, C_BMOV, OT7, OT5, O_NX);
      7'd39: u = mk(U_SUB, C_BMOV, OT6, OT6, OT7);
      7'd40: u = mk(U_MUL, C_BMOV, OT6, OT6, OT6);
      7'd41: u = mk(U_MUL, C_BMOV, OT6, OT6, OB_II);
      7'd42: u = mk(U_ADD, C_BMOV, OT6, OB_IM, OT6);
      7'd43: u = mk(U_ADD, C_BMOV, OT3, OT3, OT6);
      // impulse magnitude and vector
      7'd44: u = mk(U_MUL, C_ALL, OT6, OT2, O_REST1);
      7'd45: u = mk(U_DIVZ, C_ALL, OT3, OT6, OT3);
      7'd46: u = mk(U_MUL, C_ALL, OT6, O_NX, OT3);
      7'd47: u = mk(U_NEG, C_ALL, OT6, OT6, O_ZERO);
      7'd48: u = mk(U_MUL, C_ALL, OT7, O_NY, OT3);
      7'd49: u = mk(U_NEG, C_ALL, OT7, OT7, O_ZERO);
      // apply to body A
      7'd50: u = mk(U_MUL, C_AMOV, OT2, OT0, OT7);
      7'd51: u = mk(U_MUL, C_AMOV, OT3, OT1, OT6);
      7'd52: u = mk(U_SUB, C_AMOV, OT2, OT2, OT3);
      7'd53: u = mk(U_MUL, C_AMOV, OT2, OT2, OA_II);
      7'd54: u = mk(U_ADD, C_AMOV, OA_SP, OA_SP, OT2);
      7'd55: u = mk(U_MUL, C_AMOV, OT2, OT6, OA_IM);
      7'd56: u = mk(U_ADD, C_AMOV, OA_VX, OA_VX, OT2);
      7'd57: u = mk(U_MUL, C_AMOV, OT2, OT7, OA_IM);
      7'd58: u = mk(U_ADD, C_AMOV, OA_VY, OA_VY, OT2);
      // apply the opposite impulse to body B
      7'd59: u = mk(U_NEG, C_ALL, OT6, OT6, O_ZERO);
      7'd60: u = mk(U_NEG, C_ALL, OT7, OT7, O_ZERO);
      7'd61: u = mk(U_MUL, C_BMOV, OT2, OT4, OT7);
      7'd62: u = mk(U_MUL, C_BMOV, OT3, OT5, OT6);
      7'd63: u = mk(U_SUB, C_BMOV, OT2, OT2, OT3);
      7'd64: u = mk(U_MUL, C_BMOV, OT2, OT2, OB_II);
      7'd65: u = mk(U_ADD, C_BMOV, OB_SP, OB_SP, OT2);
      7'd66: u = mk(U_MUL, C_BMOV, OT2, OT6, OB_IM);
      7'd67: u = mk(U_ADD, C_BMOV, OB_VX, OB_VX, OT2);
      7'd68: u = mk(U_MUL, C_BMOV, OT2, OT7, OB_IM);
      7'd69: u = mk(U_ADD, C_BMOV, OB_VY, OB_VY, OT2);
      7'd70: u = mk(U_END, C_ALL, O_ZERO, O_ZERO, O_ZERO);
      // penetration correction: line direction
      7'd71: u = mk(U_NEG, C_FLAG, OT0, O_PX, O_ZERO);
      7'd72: u = mk(U_ADD, C_NFLAG, OT0, O_PX, O_ZERO);
      7'd73: u = mk(U_NEG, C_FLAG, OT1, O_PY, O_ZERO);
      7'd74: u = mk(U_ADD, C_NFLAG, OT1, O_PY, O_ZERO);
      // both movable: split by mass
      7'd75: u = mk(U_ADD, C_BOTH, OT2, OA_MS, OB_MS);
      7'd76: u = mk(U_DIV, C_BOTH, OT2, OA_MS, OT2);
      7'd77: u = mk(U_SUB, C_BOTH, OT3, O_ONE, OT2);
      7'd78: u = mk(U_MUL, C_BOTH, OT4, OT0, O_HALF);
      7'd79: u = mk(U_MUL, C_BOTH, OT5, OT1, O_HALF);
      7'd80: u = mk(U_MUL, C_BOTH, OT6, OT4, OT2);
      7'd81: u = mk(U_SUB, C_BOTH, OA_PX, OA_PX, OT6);
      7'd82: u = mk(U_MUL, C_BOTH, OT6, OT5, OT2);
      7'd83: u = mk(U_SUB, C_BOTH, OA_PY, OA_PY, OT6);
      7'd84: u = mk(U_MUL, C_BOTH, OT6, OT4, OT3);
      7'd85: u = mk(U_ADD, C_BOTH, OB_PX, OB_PX, OT6);
      7'd86: u = mk(U_MUL, C_BOTH, OT6, OT5, OT3);
      7'd87: u = mk(U_ADD, C_BOTH, OB_PY, OB_PY, OT6);
      // fixed body pushes
      7'd88: u = mk(U_ADD, C_AFIX, OB_PX, OB_PX, OT0);
      7'd89: u = mk(U_ADD, C_AFIX, OB_PY, OB_PY, OT1);
      7'd90: u = mk(U_SUB, C_BFIX, OA_PX, OA_PX, OT0);
      7'd91: u = mk(U_SUB, C_BFIX, OA_PY, OA_PY, OT1);
      default: u = mk(U_END, C_ALL, O_ZERO, O_ZERO, O_ZERO);
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] get_field(input body_t b, input logic [2:0] f);
    logic signed [31:0] v;
    case (f)
      FLD_PX:  v = b.pos_x;
      FLD_PY:  v = b.pos_y;
      FLD_VX:  v = b.vel_x;
      FLD_VY:  v = b.vel_y;
      FLD_SP:  v = b.spin;
      FLD_MS:  v = b.mass;
      FLD_IM:  v = b.inv_mass;
      default: v = b.inv_inertia;
    endcase
    return v;
  endfunction

  function automatic body_t put_field(input body_t b, input logic [2:0] f,
                                      input logic signed [31:0] v);
    body_t r;
    r = b;
    case (f)
      FLD_PX:  r.pos_x = v;
      FLD_PY:  r.pos_y = v;
      FLD_VX:  r.vel_x = v;
      FLD_VY:  r.vel_y = v;
      FLD_SP:  r.spin = v;
      FLD_MS:  r.mass = v;
      FLD_IM:  r.inv_mass = v;
      default: r.inv_inertia = v;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/rbci_if.sv
// Valid/ready channel interfaces for the item and result streams.
// Plain logic types only; no package dependency.
interface rbci_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         first_body;
  logic [5:0]         second_body;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] spin_in;
  logic [30:0]        mass_in;
  logic [30:0]        inertia_in;
  logic               fixed_in;
  logic               normal_from_a;

  modport source (
    output valid, action, first_body, second_body, vec_x, vec_y, dir_x, dir_y,
           spin_in, mass_in, inertia_in, fixed_in, normal_from_a,
    input  ready
  );
  modport sink (
    input  valid, action, first_body, second_body, vec_x, vec_y, dir_x, dir_y,
           spin_in, mass_in, inertia_in, fixed_in, normal_from_a,
    output ready
  );
endinterface

interface rbci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_spin;
  logic               impulse_applied;
  logic [31:0]        hit_total;

  modport source (
    output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_spin,
           impulse_applied, hit_total,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_spin,
           impulse_applied, hit_total,
    output ready
  );
endinterface

>>> hw/rtl/rigid_body_contact_impulse.sv
// Top level of the rigid body contact impulse block: sequencer, scratch registers, body table.
// Depends on rbci_pkg, rbci_if, rbci_ram, rbci_alu and rbci_div.
//
// Holds a table of BODY_COUNT 2D bodies in one RAM and runs one action per item: write body,
// read body, contact impulse or penetration correction, in saturating Q16.16. One item at a
// time: in_ch.ready is high only while the block is idle. Every operation of an action but a
// division runs on one shared ALU under a small microcode sequencer, one operation per cycle
// (skipped operations included), and each division holds the sequencer while the bit-serial
// divider runs. A read runs no division; a write runs two; a contact impulse runs one, which
// it skips when the contact is separating; a penetration correction runs one only when both
// bodies are movable. Table entries must be written before they are read; there is no
// clearing pass.
module rigid_body_contact_impulse (
  input  logic                          clk,
  input  logic                          rst_n,
  rbci_in_if.sink                       in_ch,
  rbci_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rbci_pkg::REST_W-1:0]   cfg_wdata
);
  import rbci_pkg::*;

  typedef struct packed {
    logic in_ready;
    logic cap_a;
    logic cap_b;
    logic ram_we;
    logic wr_b;
    logic dst_we;
    logic out_load;
  } ctl_t;

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  ctl_t                ctl;

  // Latched item
  logic [1:0]          act_r;
  logic [IDX_W-1:0]    a_r, b_r;
  logic signed [31:0]  px_r, py_r, nx_r, ny_r, spin_r;
  logic [30:0]         mass_r, iner_r;
  logic                fix_r, flag_r, bsel_r, range_ok_r;

  body_t               rec_r [2];
  logic signed [31:0]  tmp_r [NUM_TMP];
  logic [REST_W-1:0]   rest_r;
  logic [31:0]         cnt_r;
  logic                hit_r;

  logic                out_valid_r, out_hit_r;
  logic signed [31:0]  out_px_r, out_py_r, out_vx_r, out_vy_r, out_sp_r;
  logic [31:0]         out_tot_r;

  uop_t                uop;
  logic signed [31:0]  opx, opy, alu_res, div_q, dst_val;
  logic                cond_ok, fix_a, fix_b, div_done, hit_now, in_fire;
  div_req_t            div_req;
  logic [ADDR_W-1:0]   raddr, waddr;
  body_t               rdata, wdata;

  assign in_fire = in_ch.valid && ctl.in_ready;
  assign uop     = ucode(pc_r);
  assign fix_a   = rec_r[0].fixed;
  assign fix_b   = rec_r[bsel_r].fixed;
  assign hit_now = ((opx > 32'sd0) != flag_r);

  // Operand fetch
  function automatic logic signed [31:0] opd_val(input logic [5:0] c);
    logic signed [31:0] v;
    case (c[5:3])
      GRP_A: v = get_field(rec_r[0], c[2:0]);
      GRP_B: v = get_field(rec_r[bsel_r], c[2:0]);
      GRP_T: v = tmp_r[c[2:0]];
      default: begin
        case (c)
          O_ONE:   v = Q_ONE;
          O_HALF:  v = Q_HALF;
          O_PX:    v = px_r;
          O_PY:    v = py_r;
          O_NX:    v = nx_r;
          O_NY:    v = ny_r;
          O_REST1: v = Q_ONE + $signed({15'd0, rest_r});
          O_SPIN:  v = spin_r;
          O_MASS:  v = $signed({1'b0, mass_r});
          O_INER:  v = $signed({1'b0, iner_r});
          default: v = 32'sd0;
        endcase
      end
    endcase
    return v;
  endfunction

  always_comb begin
    opx = opd_val(uop.sx);
    opy = opd_val(uop.sy);
  end

  // Microcode condition
  always_comb begin
    case (uop.cond)
      C_ALL:   cond_ok = 1'b1;
      C_AMOV:  cond_ok = !fix_a;
      C_BMOV:  cond_ok = !fix_b;
      C_BOTH:  cond_ok = !fix_a && !fix_b;
      C_AFIX:  cond_ok = fix_a;
      C_BFIX:  cond_ok = fix_b;
      C_FLAG:  cond_ok = flag_r;
      default: cond_ok = !flag_r;
    endcase
  end

  rbci_alu u_alu (
    .op  (uop.op),
    .x   (opx),
    .y   (opy),
    .res (alu_res)
  );

  assign div_req.start        = (state_r == ST_RUN) && cond_ok &&
                                (uop.op == U_DIV || uop.op == U_DIVZ);
  assign div_req.zero_to_zero = (uop.op == U_DIVZ);

  rbci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (opx),
    .den   (opy),
    .done  (div_done),
    .quo   (div_q)
  );

  // Body table
  assign raddr = (state_r == ST_RDA) ? ADDR_W'(a_r) : ADDR_W'(b_r);
  assign waddr = ctl.wr_b ? ADDR_W'(b_r) : ADDR_W'(a_r);
  assign wdata = ctl.wr_b ? rec_r[1] : rec_r[0];

  rbci_ram #(
    .WIDTH (BODY_W),
    .DEPTH (BODY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state and program counter
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_LDB;
      ST_LDB: begin
        if (!range_ok_r || act_r == ACT_READ) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RUN;
          case (act_r)
            ACT_WRITE:   pc_nxt = PC_WRITE;
            ACT_CONTACT: pc_nxt = PC_CONTACT;
            default:     pc_nxt = PC_CORRECT;
          endcase
        end
      end
      ST_RUN: begin
        if (!cond_ok) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          case (uop.op)
            U_DIV, U_DIVZ: state_nxt = ST_DIVW;
            U_END:         state_nxt = ST_WBA;
            U_TEST: begin
              if (hit_now) pc_nxt = pc_r + 1'b1;
              else         state_nxt = ST_WBA;
            end
            default: pc_nxt = pc_r + 1'b1;
          endcase
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_RUN;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      ST_WBA:  state_nxt = (act_r != ACT_WRITE && bsel_r) ? ST_WBB : ST_DONE;
      ST_WBB:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl          = '0;
    dst_val      = alu_res;
    case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_RDB:  ctl.cap_a = 1'b1;
      ST_LDB:  ctl.cap_b = 1'b1;
      ST_RUN: begin
        ctl.dst_we = cond_ok && (uop.op inside {U_ADD, U_SUB, U_NEG, U_MUL});
      end
      ST_DIVW: begin
        ctl.dst_we = div_done;
        dst_val    = div_q;
      end
      ST_WBA:  ctl.ram_we = 1'b1;
      ST_WBB: begin
        ctl.ram_we = 1'b1;
        ctl.wr_b   = 1'b1;
      end
      ST_DONE: ctl.out_load = !out_valid_r || out_ch.ready;
      default: ctl = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      rest_r      <= REST_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (cfg_we) rest_r <= cfg_wdata;
      if (state_r == ST_RUN && cond_ok && uop.op == U_TEST && hit_now) begin
        cnt_r <= cnt_r + 32'd1;
      end
      if (ctl.out_load)         out_valid_r <= 1'b1;
      else if (out_ch.ready)    out_valid_r <= 1'b0;
    end
  end

  // Item latch, body records and scratch registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r      <= in_ch.action;
      a_r        <= in_ch.first_body;
      b_r        <= in_ch.second_body;
      px_r       <= in_ch.vec_x;
      py_r       <= in_ch.vec_y;
      nx_r       <= in_ch.dir_x;
      ny_r       <= in_ch.dir_y;
      spin_r     <= in_ch.spin_in;
      mass_r     <= in_ch.mass_in;
      iner_r     <= in_ch.inertia_in;
      fix_r      <= in_ch.fixed_in;
      flag_r     <= in_ch.normal_from_a;
      bsel_r     <= (in_ch.first_body != in_ch.second_body);
      range_ok_r <= (32'(in_ch.first_body) < BODY_COUNT) &&
                    ((in_ch.action == ACT_WRITE || in_ch.action == ACT_READ) ||
                     (32'(in_ch.second_body) < BODY_COUNT));
      hit_r      <= 1'b0;
    end
    if (state_r == ST_RUN && cond_ok && uop.op == U_TEST && hit_now) hit_r <= 1'b1;
    if (ctl.cap_a) rec_r[0] <= rdata;
    if (ctl.cap_b) begin
      rec_r[1] <= rdata;
      if (act_r == ACT_WRITE) rec_r[0].fixed <= fix_r;
    end
    // Result of the current operation; B refers to A when both indexes match
    if (ctl.dst_we) begin
      case (uop.dst[5:3])
        GRP_T:   tmp_r[uop.dst[2:0]] <= dst_val;
        GRP_A:   rec_r[0] <= put_field(rec_r[0], uop.dst[2:0], dst_val);
        GRP_B:   rec_r[bsel_r] <= put_field(rec_r[bsel_r], uop.dst[2:0], dst_val);
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (act_r == ACT_READ && range_ok_r) begin
        out_px_r <= rec_r[0].pos_x;
        out_py_r <= rec_r[0].pos_y;
        out_vx_r <= rec_r[0].vel_x;
        out_vy_r <= rec_r[0].vel_y;
        out_sp_r <= rec_r[0].spin;
      end else begin
        out_px_r <= '0;
        out_py_r <= '0;
        out_vx_r <= '0;
        out_vy_r <= '0;
        out_sp_r <= '0;
      end
      out_hit_r <= hit_r;
      out_tot_r <= cnt_r;
    end
  end

  assign in_ch.ready            = ctl.in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_pos_x       = out_px_r;
  assign out_ch.out_pos_y       = out_py_r;
  assign out_ch.out_vel_x       = out_vx_r;
  assign out_ch.out_vel_y       = out_vy_r;
  assign out_ch.out_spin        = out_sp_r;
  assign out_ch.impulse_applied = out_hit_r;
  assign out_ch.hit_total       = out_tot_r;
endmodule

>>> hw/rtl/rbci_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/rbci_alu.sv
// Shared Q16.16 arithmetic unit: saturating add, subtract, negate and multiply.
// Depends on rbci_pkg.
module rbci_alu (
  input  rbci_pkg::op_t             op,
  input  logic signed [31:0]        x,
  input  logic signed [31:0]        y,
  output logic signed [31:0]        res
);
  import rbci_pkg::*;

  logic signed [63:0] xw, yw, prod;

  assign xw   = {{32{x[31]}}, x};
  assign yw   = {{32{y[31]}}, y};
  assign prod = xw * yw;

  // Multiply shifts with floor rounding; everything saturates to 32 bits
  always_comb begin
    case (op)
      U_ADD:   res = sat64(xw + yw);
      U_SUB:   res = sat64(xw - yw);
      U_NEG:   res = sat64(-xw);
      U_MUL:   res = sat64(prod >>> 16);
      default: res = x;
    endcase
  end
endmodule

>>> hw/rtl/rbci_div.sv
// Iterative Q16.16 divider, one quotient bit per cycle, saturating result.
// Depends on rbci_pkg.
module rbci_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbci_pkg::div_req_t   req,
  input  logic signed [31:0]   num,
  input  logic signed [31:0]   den,
  output logic                 done,
  output logic signed [31:0]   quo
);
  import rbci_pkg::*;

  logic                     busy_r, done_r, neg_r, zero_r;
  logic [DCNT_W-1:0]        cnt_r;
  logic [DIV_STEPS-1:0]     dvd_r;
  logic [31:0]              rem_r, dvs_r;
  logic signed [31:0]       zval_r;
  logic [31:0]              num_mag, den_mag;
  logic [32:0]              rem_sh, diff;
  logic                     ge;

  assign num_mag = num[31] ? (~num + 32'd1) : num;
  assign den_mag = den[31] ? (~den + 32'd1) : den;
  assign rem_sh  = {rem_r, dvd_r[DIV_STEPS-1]};
  assign diff    = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (den == 32'sd0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DCNT_W'(DIV_STEPS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division datapath; quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      zero_r <= (den == 32'sd0);
      if (req.zero_to_zero || num == 32'sd0) zval_r <= 32'sd0;
      else if (num[31])                      zval_r <= Q_MIN;
      else                                   zval_r <= Q_MAX;
      neg_r  <= num[31] ^ den[31];
      dvd_r  <= {num_mag, 16'd0};
      dvs_r  <= den_mag;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[DIV_STEPS-2:0], ge};
    end
  end

  // Sign and saturation
  always_comb begin
    if (zero_r) begin
      quo = zval_r;
    end else if (neg_r) begin
      if (dvd_r > 48'h0000_8000_0000) quo = Q_MIN;
      else                            quo = -$signed(dvd_r[31:0]);
    end else begin
      if (dvd_r > 48'h0000_7fff_ffff) quo = Q_MAX;
      else                            quo = $signed(dvd_r[31:0]);
    end
  end

  assign done = done_r;
endmodule

>>> hw/rtl/rbci_chk.sv
// Port-level checker for the rigid body contact impulse block, bound to the top level.
// No package dependency.
module rbci_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_pos_x
);
  // A result waits until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit_total) && $stable(out_pos_x))
    else $error("stalled result item changed");

  // One item at a time: an accepted item closes the input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an item was accepted");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind rigid_body_contact_impulse rbci_chk u_rbci_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_hit_total (out_ch.hit_total),
  .out_pos_x     (out_ch.out_pos_x)
);
